// ===== design/olmbo_pkg.sv =====
// Shared types and constants for the ordered list move-by-offset block.
package olmbo_pkg;

  localparam int CAPACITY_DEF = 64;   // default number of list slots
  localparam int ID_W         = 7;    // id, read index and config field width
  localparam int OFF_W        = 8;    // signed offset width
  localparam int STAT_W       = 2;
  localparam int ACT_W        = 2;
  localparam int LEN_RST      = 64;   // list length after reset, before clamping
  localparam logic [ID_W-1:0] INIT_COUNT_RST = ID_W'(64);

  typedef enum logic [ACT_W-1:0] {
    ACT_MOVE    = 2'd0,
    ACT_READ    = 2'd1,
    ACT_RESTART = 2'd2
  } act_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DROPPED   = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_FILL,    // sweep list slots with 1..CAPACITY
    S_IDLE,
    S_SRD,     // search: issue read of slot k
    S_SCHK,    // search: compare slot k with the id
    S_PLAN,    // work out shift direction and end slot
    S_CRD,     // shift: read neighbor slot
    S_CWR,     // shift: write it into slot k
    S_PUT,     // write the moved id into its new slot
    S_RRD,     // read: issue read of the indexed slot
    S_RWT,     // read: capture data
    S_DONE     // result strobe
  } state_t;

endpackage

// ===== design/olmbo_mem.sv =====
// Single-port-write list store with registered read.
module olmbo_mem
  import olmbo_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW    = $clog2(CAPACITY_DEF),
  parameter int DW    = $clog2(CAPACITY_DEF + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/olmbo_seq.sv =====
// Sequencer: id search, one-slot-per-step shifting, reads and refill sweeps.
module olmbo_seq
  import olmbo_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY_DEF),
  parameter int LW       = $clog2(CAPACITY_DEF + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [ACT_W-1:0]        action,
  input  logic [ID_W-1:0]         student_id,
  input  logic signed [OFF_W-1:0] offset,
  input  logic [ID_W-1:0]         read_index,
  input  logic [LW-1:0]           fill_len,
  output logic                    busy,
  output logic                    done,
  output logic [STAT_W-1:0]       status,
  output logic [ID_W-1:0]         entry_value,
  output logic [ID_W-1:0]         list_length,
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output logic [LW-1:0]           mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic [LW-1:0]           mem_rdata
);

  localparam int CW      = (LW > ID_W) ? LW : ID_W;
  localparam int TW      = ((LW > OFF_W) ? LW : OFF_W) + 2;
  localparam int RST_LEN = (CAPACITY < LEN_RST) ? CAPACITY : LEN_RST;

  state_t                 state, state_next;
  logic [AW-1:0]          k;
  logic [AW-1:0]          end_pos;
  logic                   dir_left;
  logic                   put_en;
  logic                   fill_rsp;
  logic [LW-1:0]          len;
  logic [LW-1:0]          moved;
  logic [ID_W-1:0]        id_q;
  logic signed [OFF_W-1:0] off_q;
  logic [ID_W-1:0]        ridx_q;
  status_t                status_q;
  logic [ID_W-1:0]        value_q;

  logic                   match;
  logic                   k_last;
  logic [AW-1:0]          src;
  logic signed [TW-1:0]   t_s;
  logic                   in_range;
  logic [AW-1:0]          plan_end;
  logic                   read_ok;

  assign match    = CW'(mem_rdata) == CW'(id_q);
  assign k_last   = (LW'(k) + LW'(1)) == len;
  assign src      = dir_left ? (k + AW'(1)) : (k - AW'(1));
  // new 0-based slot = found slot + offset
  assign t_s      = signed'(TW'(k)) + TW'(off_q);
  assign in_range = !t_s[TW-1] && (t_s < signed'(TW'(len)));
  assign plan_end = in_range ? AW'(t_s) : AW'(len - LW'(1));
  assign read_ok  = (read_index != '0) && (CW'(read_index) <= CW'(len));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_FILL: begin
        if (k == AW'(CAPACITY - 1)) begin
          state_next = fill_rsp ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_MOVE:    state_next = (len == '0) ? S_DONE : S_SRD;
            ACT_READ:    state_next = read_ok ? S_RRD : S_DONE;
            ACT_RESTART: state_next = S_FILL;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_SRD:  state_next = S_SCHK;
      S_SCHK: begin
        if (match) begin
          state_next = S_PLAN;
        end else if (k_last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_SRD;
        end
      end
      S_PLAN: begin
        if (plan_end == k) begin
          state_next = in_range ? S_PUT : S_DONE;
        end else begin
          state_next = S_CRD;
        end
      end
      S_CRD: state_next = S_CWR;
      S_CWR: begin
        if (src == end_pos) begin
          state_next = put_en ? S_PUT : S_DONE;
        end else begin
          state_next = S_CRD;
        end
      end
      S_PUT:  state_next = S_DONE;
      S_RRD:  state_next = S_RWT;
      S_RWT:  state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k;
    mem_wdata = mem_rdata;
    mem_raddr = k;
    busy      = 1'b1;
    done      = 1'b0;
    case (state)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = LW'(k) + LW'(1);
      end
      S_IDLE: busy = 1'b0;
      S_CRD:  mem_raddr = src;
      S_CWR:  mem_we = 1'b1;
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = end_pos;
        mem_wdata = moved;
      end
      S_RRD:  mem_raddr = AW'(ridx_q - ID_W'(1));
      S_DONE: done = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_FILL;
      k        <= '0;
      len      <= LW'(RST_LEN);
      fill_rsp <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_FILL: k <= k + AW'(1);
        S_IDLE: begin
          k        <= '0;
          fill_rsp <= 1'b0;
          id_q     <= student_id;
          off_q    <= offset;
          ridx_q   <= read_index;
          status_q <= ST_OK;
          value_q  <= '0;
          if (start) begin
            case (action)
              ACT_MOVE: begin
                if (len == '0) begin
                  status_q <= ST_NOT_FOUND;
                end
              end
              ACT_READ: begin
                if (!read_ok) begin
                  status_q <= ST_BAD_INDEX;
                end
              end
              ACT_RESTART: begin
                len      <= fill_len;
                fill_rsp <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        S_SCHK: begin
          if (match) begin
            moved <= mem_rdata;
          end else if (k_last) begin
            status_q <= ST_NOT_FOUND;
          end else begin
            k <= k + AW'(1);
          end
        end
        S_PLAN: begin
          end_pos <= plan_end;
          put_en  <= in_range;
          // a forward move and a drop both close the gap toward the front
          dir_left <= !in_range || (AW'(t_s) >= k);
          if (!in_range) begin
            status_q <= ST_DROPPED;
            len      <= len - LW'(1);
          end
        end
        S_CWR:  k <= src;
        S_RWT:  value_q <= ID_W'(mem_rdata);
        default: ;
      endcase
    end
  end

  assign status      = status_q;
  assign entry_value = value_q;
  assign list_length = ID_W'(len);

endmodule

// ===== design/ordered_list_move_by_offset_core.sv =====
// Top level: config register, list sequencer and list store.
// Ordered list of unique ids with move-by-offset. Raise start while busy is
// low to hand in one transaction; exactly one result follows, shown for a
// single cycle with done high, and it must be taken then since it cannot be
// stalled. All work goes through one list store with one write and one
// registered read per cycle. A move searches the slots in order for the id,
// shifts the slots between its old and new place one at a time and then
// writes the id unless it is dropped; a restart sweeps all CAPACITY slots.
// After reset the store is swept with busy high. Write initial_count only
// while busy is low.
module ordered_list_move_by_offset_core
  import olmbo_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [ID_W-1:0]         cfg_wr_data,
  input  logic                    start,
  output logic                    busy,
  input  logic [ACT_W-1:0]        action,
  input  logic [ID_W-1:0]         student_id,
  input  logic signed [OFF_W-1:0] offset,
  input  logic [ID_W-1:0]         read_index,
  output logic                    done,
  output logic [STAT_W-1:0]       status,
  output logic [ID_W-1:0]         entry_value,
  output logic [ID_W-1:0]         list_length
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic [ID_W-1:0] initial_count;
  logic [LW-1:0]   fill_len;
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [LW-1:0]   mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [LW-1:0]   mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      initial_count <= INIT_COUNT_RST;
    end else if (cfg_wr_en) begin
      initial_count <= cfg_wr_data;
    end
  end

  // clamp the restart count to the store size
  assign fill_len = (int'(initial_count) > CAPACITY) ? LW'(CAPACITY) : LW'(initial_count);

  olmbo_seq #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .action      (action),
    .student_id  (student_id),
    .offset      (offset),
    .read_index  (read_index),
    .fill_len    (fill_len),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .entry_value (entry_value),
    .list_length (list_length),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  olmbo_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (LW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
